[rtl/tlg_pkg.sv]
package tlg_pkg;

  // Default grid limits
  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;

  // Field widths
  localparam int CFG_W      = 7;
  localparam int ROW_W      = 6;
  localparam int COL_W      = 6;
  localparam int KIND_W     = 2;
  localparam int ROW_BITS_W = 64;
  localparam int ADDR_W     = 3;
  localparam int PDATA_W    = 32;

  // Input kinds
  localparam logic [KIND_W-1:0] KIND_TOGGLE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EVOLVE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd3;

  // Register index, taken from paddr[2]
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  // Control broadcast from the sequencer to every row cell
  typedef struct packed {
    logic             clear;
    logic             shift;
    logic             flip;
    logic [ROW_W-1:0] flip_row;
    logic [COL_W-1:0] flip_col;
    logic [ROW_W-1:0] ring_last;
  } tlg_ctl_t;

endpackage

[rtl/tlg_row_cell.sv]
module tlg_row_cell #(
  parameter int W   = tlg_pkg::DEF_MAX_COLS,
  parameter int IDX = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  tlg_pkg::tlg_ctl_t  ctl,
  input  logic [W-1:0]       next_word,
  input  logic [W-1:0]       feed,
  output logic [W-1:0]       word
);

  localparam logic [tlg_pkg::ROW_W-1:0] MY_IDX = tlg_pkg::ROW_W'(IDX);

  // Hold one grid row; rotate within the active ring, take the feed at its end
  always_ff @(posedge clk) begin
    if (rst) begin
      word <= '0;
    end else if (ctl.clear) begin
      word <= '0;
    end else if (ctl.shift) begin
      if (MY_IDX == ctl.ring_last) begin
        word <= feed;
      end else if (MY_IDX < ctl.ring_last) begin
        word <= next_word;
      end
    end else if (ctl.flip && (ctl.flip_row == MY_IDX)) begin
      word <= word ^ (W'(1) << ctl.flip_col);
    end
  end

endmodule

[rtl/tlg_next_row.sv]
module tlg_next_row #(
  parameter int W = tlg_pkg::DEF_MAX_COLS
) (
  input  logic [W-1:0]                up,
  input  logic [W-1:0]                mid,
  input  logic [W-1:0]                down,
  input  logic [tlg_pkg::COL_W-1:0]   last_col,
  input  logic                        single_row,
  output logic [W-1:0]                new_word
);

  // Apply the birth and survival rule to every column at once
  always_comb begin
    logic [tlg_pkg::COL_W-1:0] lidx;
    logic [tlg_pkg::COL_W-1:0] ridx;
    logic [3:0]                n_mid;
    logic [3:0]                n_up;
    logic [3:0]                n_dn;
    logic [3:0]                n_all;
    logic                      single_col;
    single_col = (last_col == '0);
    new_word   = '0;
    for (int c = 0; c < W; c++) begin
      // Wrap column neighbours over the active width
      lidx = (c == 0) ? last_col : tlg_pkg::COL_W'(c - 1);
      if ((c == W - 1) || (tlg_pkg::COL_W'(c) == last_col)) begin
        ridx = '0;
      end else begin
        ridx = tlg_pkg::COL_W'(c + 1);
      end
      // Centre row: skip offsets landing on the cell itself
      n_mid = single_col ? 4'd0 : (4'(mid[lidx]) + 4'(mid[ridx]));
      n_up  = single_row ? n_mid : (4'(up[lidx]) + 4'(up[c]) + 4'(up[ridx]));
      n_dn  = single_row ? n_mid : (4'(down[lidx]) + 4'(down[c]) + 4'(down[ridx]));
      n_all = n_mid + n_up + n_dn;
      new_word[c] = (tlg_pkg::COL_W'(c) <= last_col) &&
                    ((n_all == 4'd3) || ((n_all == 4'd2) && mid[c]));
    end
  end

endmodule

[rtl/toroidal_life_grid.sv]
// Game of Life on a wrapped grid of up to MAX_ROWS x MAX_COLS cells. The grid sits in a
// chain of row cells that rotates over the active rows, one row per cycle unless held,
// with the row at the head of the chain feeding the next-generation logic. Toggle and
// clear are applied as they are taken, and the block stays ready for the next input. A
// read of row 0, or of a row beyond the active rows, sends its row without turning the
// chain; any other read turns the chain until the row reaches the head, sends the row,
// and turns the chain on back to its rest position. Evolve makes one new row per cycle
// while the result side takes them, each sent as it is made; after a write to the rows
// register it first makes one extra full turn of the chain to pick up the last active
// row, until a clear or an evolve refreshes that copy. A result stall stops the chain
// while it has a row to send. Inputs are taken only while no item is in progress.
module toroidal_life_grid #(
  parameter int MAX_ROWS = tlg_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = tlg_pkg::DEF_MAX_COLS
) (
  input  logic                          clk,
  input  logic                          rst,
  // Input stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [15:0]                   s_tdata,   // row[5:0], col[11:6], zero pad
  input  logic [tlg_pkg::KIND_W-1:0]    s_tuser,   // kind[1:0]
  // Result stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [71:0]                   m_tdata,   // row_index[5:0], row_bits[69:6], pad
  output logic                          m_tlast,   // last
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tlg_pkg::ADDR_W-1:0]    paddr,
  input  logic [tlg_pkg::PDATA_W-1:0]   pwdata,
  output logic [tlg_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int CFG_W = tlg_pkg::CFG_W;
  localparam int ROW_W = tlg_pkg::ROW_W;
  localparam int COL_W = tlg_pkg::COL_W;

  localparam logic [CFG_W-1:0] ROWS_MAX = CFG_W'(MAX_ROWS);
  localparam logic [CFG_W-1:0] COLS_MAX = CFG_W'(MAX_COLS);
  localparam logic [ROW_W-1:0] LAST_ROW_MAX = ROW_W'(MAX_ROWS - 1);
  localparam logic [COL_W-1:0] LAST_COL_MAX = COL_W'(MAX_COLS - 1);

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_PREP      = 3'd1;
  localparam logic [2:0] ST_EVOLVE    = 3'd2;
  localparam logic [2:0] ST_READ      = 3'd3;
  localparam logic [2:0] ST_READ_BACK = 3'd4;
  localparam logic [2:0] ST_READ_ZERO = 3'd5;

  logic [CFG_W-1:0]    rows_cfg;
  logic [CFG_W-1:0]    cols_cfg;
  logic [2:0]          state;
  logic [ROW_W-1:0]    base;
  logic [ROW_W-1:0]    row_q;
  logic [MAX_COLS-1:0] prev;
  logic [MAX_COLS-1:0] first;
  logic [MAX_COLS-1:0] last_row;
  logic                last_ok;
  logic [ROW_W-1:0]    out_index;
  logic [MAX_COLS-1:0] out_bits;
  logic                out_last;

  logic [ROW_W-1:0]    ring_last;
  logic [COL_W-1:0]    last_col;
  logic [MAX_COLS-1:0] col_mask;
  logic [MAX_COLS-1:0] cell_word [MAX_ROWS];
  logic [MAX_COLS-1:0] head;
  logic [MAX_COLS-1:0] below;
  logic [MAX_COLS-1:0] gen_word;
  logic [MAX_COLS-1:0] feed;
  tlg_pkg::tlg_ctl_t   ctl;

  logic                accept;
  logic                cfg_write;
  logic [ROW_W-1:0]    row_in;
  logic [COL_W-1:0]    col_in;
  logic                row_ok;
  logic                col_ok;
  logic                out_free;
  logic                base_at_last;
  logic [ROW_W-1:0]    base_step;
  logic                out_load;
  logic [ROW_W-1:0]    out_index_next;
  logic [MAX_COLS-1:0] out_bits_next;
  logic                out_last_next;

  // Unpack the input transaction
  assign row_in   = s_tdata[5:0];
  assign col_in   = s_tdata[11:6];
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // Configuration access
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = tlg_pkg::PDATA_W'((paddr[2] == tlg_pkg::REG_COLS) ? cols_cfg : rows_cfg);

  // Clamp the active size to 1..maximum
  always_comb begin
    if (rows_cfg == '0) begin
      ring_last = '0;
    end else if (rows_cfg > ROWS_MAX) begin
      ring_last = LAST_ROW_MAX;
    end else begin
      ring_last = ROW_W'(rows_cfg - CFG_W'(1));
    end
    if (cols_cfg == '0) begin
      last_col = '0;
    end else if (cols_cfg > COLS_MAX) begin
      last_col = LAST_COL_MAX;
    end else begin
      last_col = COL_W'(cols_cfg - CFG_W'(1));
    end
  end

  always_comb begin
    for (int c = 0; c < MAX_COLS; c++) begin
      col_mask[c] = (COL_W'(c) <= last_col);
    end
  end

  assign row_ok       = (row_in <= ring_last);
  assign col_ok       = (col_in <= last_col);
  assign out_free     = !m_tvalid || m_tready;
  assign base_at_last = (base == ring_last);
  assign base_step    = base_at_last ? '0 : (base + ROW_W'(1));

  // Chain of row cells
  genvar j;
  generate
    for (j = 0; j < MAX_ROWS; j++) begin : g_cell
      tlg_row_cell #(
        .W   (MAX_COLS),
        .IDX (j)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctl       (ctl),
        .next_word (cell_word[(j + 1) % MAX_ROWS]),
        .feed      (feed),
        .word      (cell_word[j])
      );
    end
  endgenerate

  assign head  = cell_word[0];
  assign below = base_at_last ? ((base == '0) ? head : first) : cell_word[1 % MAX_ROWS];

  tlg_next_row #(
    .W (MAX_COLS)
  ) u_next (
    .up         (prev),
    .mid        (head),
    .down       (below),
    .last_col   (last_col),
    .single_row (ring_last == '0),
    .new_word   (gen_word)
  );

  // Drive the chain and the result register
  always_comb begin
    ctl            = '0;
    ctl.ring_last  = ring_last;
    ctl.flip_row   = row_in;
    ctl.flip_col   = col_in;
    feed           = head;
    out_load       = 1'b0;
    out_index_next = base;
    out_bits_next  = gen_word;
    out_last_next  = base_at_last;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          ctl.flip  = (s_tuser == tlg_pkg::KIND_TOGGLE) && row_ok && col_ok;
          ctl.clear = (s_tuser == tlg_pkg::KIND_CLEAR);
        end
      end
      ST_PREP: begin
        ctl.shift = 1'b1;
      end
      ST_EVOLVE: begin
        if (out_free) begin
          ctl.shift = 1'b1;
          feed      = gen_word;
          out_load  = 1'b1;
        end
      end
      ST_READ: begin
        out_index_next = row_q;
        out_bits_next  = head & col_mask;
        out_last_next  = 1'b1;
        if (base == row_q) begin
          if (out_free) begin
            out_load  = 1'b1;
            ctl.shift = (base != '0);
          end
        end else begin
          ctl.shift = 1'b1;
        end
      end
      ST_READ_BACK: begin
        ctl.shift = 1'b1;
      end
      ST_READ_ZERO: begin
        out_index_next = row_q;
        out_bits_next  = '0;
        out_last_next  = 1'b1;
        out_load       = out_free;
      end
      default: begin
        ctl.shift = 1'b0;
      end
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_index <= out_index_next;
      out_bits  <= out_bits_next;
      out_last  <= out_last_next;
    end
  end

  assign m_tdata = {2'b00, tlg_pkg::ROW_BITS_W'(out_bits), out_index};
  assign m_tlast = out_last;

  // Sequencer and copy of the last active row
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      base     <= '0;
      rows_cfg <= CFG_W'(64);
      cols_cfg <= CFG_W'(64);
      last_row <= '0;
      last_ok  <= 1'b1;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (s_tuser)
              tlg_pkg::KIND_TOGGLE: begin
                if (row_ok && col_ok && (row_in == ring_last)) begin
                  last_row <= last_row ^ (MAX_COLS'(1) << col_in);
                end
              end
              tlg_pkg::KIND_CLEAR: begin
                last_row <= '0;
                last_ok  <= 1'b1;
              end
              tlg_pkg::KIND_EVOLVE: begin
                if (last_ok) begin
                  prev  <= last_row;
                  state <= ST_EVOLVE;
                end else begin
                  state <= ST_PREP;
                end
              end
              default: begin
                row_q <= row_in;
                state <= row_ok ? ST_READ : ST_READ_ZERO;
              end
            endcase
          end
        end
        ST_PREP: begin
          // Turn once round the ring, picking up the last active row
          base <= base_step;
          if (base_at_last) begin
            prev     <= head;
            last_row <= head;
            last_ok  <= 1'b1;
            state    <= ST_EVOLVE;
          end
        end
        ST_EVOLVE: begin
          if (out_free) begin
            prev <= head;
            base <= base_step;
            if (base == '0) begin
              first <= head;
            end
            if (base_at_last) begin
              last_row <= gen_word;
              state    <= ST_IDLE;
            end
          end
        end
        ST_READ: begin
          if (base == row_q) begin
            if (out_free) begin
              if (base == '0) begin
                state <= ST_IDLE;
              end else begin
                base  <= base_step;
                state <= base_at_last ? ST_IDLE : ST_READ_BACK;
              end
            end
          end else begin
            base <= base_step;
          end
        end
        ST_READ_BACK: begin
          base <= base_step;
          if (base_at_last) begin
            state <= ST_IDLE;
          end
        end
        ST_READ_ZERO: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      // Register writes; a new row count drops the last-row copy
      if (cfg_write) begin
        if (paddr[2] == tlg_pkg::REG_ROWS) begin
          rows_cfg <= pwdata[CFG_W-1:0];
          last_ok  <= 1'b0;
        end else begin
          cols_cfg <= pwdata[CFG_W-1:0];
        end
      end
    end
  end

endmodule

[rtl/tlg_checker.sv]
module tlg_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_tvalid,
  input logic                        s_tready,
  input logic [tlg_pkg::KIND_W-1:0]  s_tuser,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [71:0]                 m_tdata,
  input logic                        m_tlast
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  // No new input while a generation is still being sent
  a_busy_evolve: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !s_tready)
    else $error("input taken in the middle of a generation");

  // Evolve and read occupy the block after their transaction
  a_long_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready &&
    (s_tuser == tlg_pkg::KIND_EVOLVE || s_tuser == tlg_pkg::KIND_READ) |=> !s_tready)
    else $error("ready after evolve or read transaction");

  // Toggle and clear leave the block ready for the next transaction
  a_short_free: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready &&
    (s_tuser == tlg_pkg::KIND_TOGGLE || s_tuser == tlg_pkg::KIND_CLEAR) |=> s_tready)
    else $error("not ready after toggle or clear transaction");

endmodule

bind toroidal_life_grid tlg_checker u_tlg_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

[tb/sv/tb_toroidal_life_grid.sv]
module tb_toroidal_life_grid;
  import tlg_pkg::*;

  localparam int GRID_ROWS = DEF_MAX_ROWS;
  localparam int GRID_COLS = DEF_MAX_COLS;
  // A read may keep the row chain turning for a while after its row leaves
  localparam int SETTLE_CYCLES = 160;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int RANDOM_PHASE_ITEMS = 34;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam logic [ADDR_W-1:0] ADDR_ROWS = {REG_ROWS, 2'b00};
  localparam logic [ADDR_W-1:0] ADDR_COLS = {REG_COLS, 2'b00};

  typedef struct {
    logic [ROW_W-1:0]      row_index;
    logic [ROW_BITS_W-1:0] row_bits;
    logic                  last;
  } row_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [15:0]         s_tdata = '0;   // row[5:0], col[11:6], zero pad
  logic [KIND_W-1:0]   s_tuser = '0;   // kind[1:0]
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [71:0]         m_tdata;        // row_index[5:0], row_bits[69:6], pad
  logic                m_tlast;        // last
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [PDATA_W-1:0]  pwdata = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  // Shadow of the grid and its size registers
  logic [GRID_COLS-1:0] live_grid [GRID_ROWS];
  logic [CFG_W-1:0]     rows_raw = 7'd64;
  logic [CFG_W-1:0]     cols_raw = 7'd64;
  row_result_t          expected_rows [$];

  int          error_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_req = 0;
  int          hold_left = 0;
  int unsigned cycle_count = 0;

  toroidal_life_grid dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Clamp a raw size register to the range the grid can hold
  function automatic int unsigned active_size(input logic [CFG_W-1:0] raw, input int unsigned lim);
    if (raw == '0) return 1;
    if (raw > lim) return lim;
    return int'(raw);
  endfunction

  function automatic logic [GRID_COLS-1:0] column_mask(input int unsigned nc);
    if (nc >= GRID_COLS) return '1;
    return (64'd1 << nc) - 64'd1;
  endfunction

  // Count neighbours on the torus, skipping any offset that wraps onto the centre
  function automatic int unsigned live_neighbours(input int unsigned r, c, nr, nc);
    int unsigned total;
    int unsigned y;
    int unsigned x;
    total = 0;
    for (int unsigned dy = 0; dy < 3; dy++) begin
      y = (r + nr + dy - 1) % nr;
      for (int unsigned dx = 0; dx < 3; dx++) begin
        x = (c + nc + dx - 1) % nc;
        if (!(y == r && x == c)) total += live_grid[y][x];
      end
    end
    return total;
  endfunction

  // Apply one accepted transaction to the shadow grid and queue the rows it yields
  task automatic grid_apply(input logic [KIND_W-1:0] kind, input logic [ROW_W-1:0] row,
                            input logic [COL_W-1:0] col);
    int unsigned          nr;
    int unsigned          nc;
    int unsigned          n;
    logic [GRID_COLS-1:0] mask;
    logic [GRID_COLS-1:0] next_gen [GRID_ROWS];
    nr = active_size(rows_raw, GRID_ROWS);
    nc = active_size(cols_raw, GRID_COLS);
    mask = column_mask(nc);
    case (kind)
      KIND_TOGGLE: begin
        if (row < nr && col < nc) live_grid[row][col] = ~live_grid[row][col];
      end
      KIND_CLEAR: begin
        foreach (live_grid[i]) live_grid[i] = '0;
      end
      KIND_EVOLVE: begin
        for (int unsigned r = 0; r < nr; r++) begin
          next_gen[r] = '0;
          for (int unsigned c = 0; c < nc; c++) begin
            n = live_neighbours(r, c, nr, nc);
            if (n == 3 || (n == 2 && live_grid[r][c])) next_gen[r][c] = 1'b1;
          end
        end
        for (int unsigned r = 0; r < nr; r++) begin
          live_grid[r] = next_gen[r];
          expected_rows.push_back('{row_index: ROW_W'(r), row_bits: next_gen[r],
                                   last: (r + 1 == nr)});
        end
      end
      default: begin
        expected_rows.push_back('{row_index: row,
                                 row_bits: (row < nr) ? (live_grid[row] & mask) : '0,
                                 last: 1'b1});
      end
    endcase
  endtask

  // Offer one transaction after a random gap and hold it until accepted
  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [ROW_W-1:0] row,
                           input logic [COL_W-1:0] col);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {4'd0, col, row};
    do @(posedge clk); while (!s_tready);
    grid_apply(kind, row, col);
  endtask

  // Drop valid, wait for every queued row, then let the chain settle
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Setup and access phase; psel is left high for a following write
  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [CFG_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= ($urandom() & ~32'h7F) | PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic set_grid_size(input logic [CFG_W-1:0] nrows, input logic [CFG_W-1:0] ncols);
    wait_idle();
    write_reg(ADDR_ROWS, nrows);
    rows_raw = nrows;
    write_reg(ADDR_COLS, ncols);
    cols_raw = ncols;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Mostly small sizes, now and then zero or beyond the maximum
  function automatic logic [CFG_W-1:0] pick_size();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 5) return '0;
    if (pick < 10) return CFG_W'($urandom_range(127, 65));
    if (pick < 55) return CFG_W'($urandom_range(8, 1));
    if (pick < 85) return CFG_W'($urandom_range(32, 9));
    return CFG_W'($urandom_range(64, 33));
  endfunction

  // Receiver: honour a requested hold-off, otherwise stall at random
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left != 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare each result transaction with the oldest queued row
  always @(posedge clk) begin
    row_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_rows.size() == 0) begin
        $error("row_index: expected none, got %0d", m_tdata[5:0]);
        error_count++;
      end else begin
        want = expected_rows.pop_front();
        if (m_tdata[5:0] !== want.row_index) begin
          $error("row_index: expected %0d, got %0d", want.row_index, m_tdata[5:0]);
          error_count++;
        end
        if (m_tdata[69:6] !== want.row_bits) begin
          $error("row_bits: expected %h, got %h", want.row_bits, m_tdata[69:6]);
          error_count++;
        end
        if (m_tlast !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, m_tlast);
          error_count++;
        end
      end
    end
  end

  // Four corners meet as a block across both wraps and must stay put
  task automatic test_corner_block();
    send_item(KIND_READ, 6'd63, 6'd0);
    send_item(KIND_TOGGLE, 6'd0, 6'd0);
    send_item(KIND_TOGGLE, 6'd0, 6'd63);
    send_item(KIND_TOGGLE, 6'd63, 6'd0);
    send_item(KIND_TOGGLE, 6'd63, 6'd63);
    send_item(KIND_EVOLVE, 6'd0, 6'd0);
    send_item(KIND_READ, 6'd0, 6'd63);
  endtask

  task automatic test_clear_grid();
    send_item(KIND_CLEAR, 6'd63, 6'd63);
    send_item(KIND_READ, 6'd0, 6'd0);
  endtask

  // Toggles past the active edge are dropped; a read past it returns zero
  task automatic test_small_grid_edges();
    set_grid_size(7'd3, 7'd5);
    send_item(KIND_TOGGLE, 6'd3, 6'd0);
    send_item(KIND_TOGGLE, 6'd0, 6'd5);
    send_item(KIND_TOGGLE, 6'd1, 6'd1);
    send_item(KIND_TOGGLE, 6'd1, 6'd2);
    send_item(KIND_TOGGLE, 6'd1, 6'd3);
    send_item(KIND_EVOLVE, 6'd0, 6'd0);
    send_item(KIND_READ, 6'd3, 6'd0);
  endtask

  // Zero rows counts as one row, so the row above and below is the row itself
  task automatic test_single_row();
    set_grid_size(7'd0, 7'd127);
    send_item(KIND_TOGGLE, 6'd0, 6'd40);
    send_item(KIND_TOGGLE, 6'd0, 6'd41);
    send_item(KIND_EVOLVE, 6'd0, 6'd0);
  endtask

  // One column hides the stored upper bits; evolve writes them back as zero
  task automatic test_narrow_grid();
    set_grid_size(7'd2, 7'd1);
    send_item(KIND_READ, 6'd0, 6'd0);
    send_item(KIND_TOGGLE, 6'd0, 6'd0);
    send_item(KIND_EVOLVE, 6'd0, 6'd0);
    send_item(KIND_READ, 6'd1, 6'd0);
  endtask

  // Row two was outside the last evolves and must still hold its old cells
  task automatic test_inactive_rows();
    set_grid_size(7'd64, 7'd64);
    send_item(KIND_READ, 6'd2, 6'd0);
    send_item(KIND_CLEAR, 6'd0, 6'd0);
  endtask

  // Stall results long enough to back the block up, then drain before going on
  task automatic test_result_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_grid_size(7'd8, 7'd8);
    send_item(KIND_CLEAR, 6'd0, 6'd0);
    send_item(KIND_TOGGLE, 6'd0, 6'd1);
    send_item(KIND_TOGGLE, 6'd1, 6'd2);
    send_item(KIND_TOGGLE, 6'd2, 6'd0);
    send_item(KIND_TOGGLE, 6'd2, 6'd1);
    send_item(KIND_TOGGLE, 6'd2, 6'd2);
    hold_req = LONG_HOLD_CYCLES;
    send_item(KIND_EVOLVE, 6'd0, 6'd0);
    send_item(KIND_EVOLVE, 6'd0, 6'd0);
    send_item(KIND_READ, 6'd2, 6'd0);
    send_item(KIND_EVOLVE, 6'd0, 6'd0);
    wait_idle();
  endtask

  // Resize, usually clear, seed a pattern, then mix evolves, reads and noise
  task automatic run_random_phase(input int send_pct, input int recv_pct);
    int unsigned       phase_items;
    int unsigned       nr;
    int unsigned       nc;
    int unsigned       pick;
    logic [KIND_W-1:0] kind;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    phase_items = 0;
    while (phase_items < RANDOM_PHASE_ITEMS) begin
      set_grid_size(pick_size(), pick_size());
      nr = active_size(rows_raw, GRID_ROWS);
      nc = active_size(cols_raw, GRID_COLS);
      if ($urandom_range(3) != 0) begin
        send_item(KIND_CLEAR, ROW_W'($urandom), COL_W'($urandom));
        phase_items++;
      end
      repeat ($urandom_range(10, 4)) begin
        send_item(KIND_TOGGLE, ROW_W'($urandom_range(nr - 1)), COL_W'($urandom_range(nc - 1)));
        phase_items++;
      end
      repeat ($urandom_range(12, 6)) begin
        pick = $urandom_range(99);
        row = ($urandom_range(9) == 0) ? ROW_W'($urandom) : ROW_W'($urandom_range(nr - 1));
        col = ($urandom_range(9) == 0) ? COL_W'($urandom) : COL_W'($urandom_range(nc - 1));
        if (pick < 45) kind = KIND_TOGGLE;
        else if (pick < 70) kind = KIND_READ;
        else if (pick < 94) kind = KIND_EVOLVE;
        else kind = KIND_CLEAR;
        send_item(kind, row, col);
        if (!(kind == KIND_TOGGLE && (row >= nr || col >= nc))) phase_items++;
      end
    end
  endtask

  initial begin
    foreach (live_grid[i]) live_grid[i] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_corner_block();
    test_clear_grid();
    test_small_grid_edges();
    test_single_row();
    test_narrow_grid();
    test_inactive_rows();
    test_result_backpressure();
    run_random_phase(0, 0);
    run_random_phase(69, 0);
    run_random_phase(0, 69);
    run_random_phase(30, 30);
    wait_idle();
    if (error_count == 0) begin
      $display("tb_toroidal_life_grid: done, clean");
    end else begin
      $display("tb_toroidal_life_grid: done, errors");
    end
    $finish;
  end

  // Abort a hung run
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb_toroidal_life_grid: done, errors");
    $finish;
  end

endmodule
